### src/rau_pkg.sv
package rau_pkg;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_MUL = 2'd1,
      MODE_DIV = 2'd2,
      MODE_RED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DIVZ = 2'd1,
      ST_OVF  = 2'd2
   } status_type;

   localparam int NUM_W  = 32;
   localparam int DEN_W  = 31;
   localparam int WIDE_W = 64;

endpackage

### src/rational_arithmetic_unit.sv
// Sequencing: a bad operand goes from the check state straight to the response state. Otherwise
// every Euclid step and each final divide runs on the shared 64-bit restoring divider
// (one quotient bit per cycle); add takes a 31-bit gcd, reduce the gcd of a 32-bit
// magnitude and a 31-bit denominator, and multiply and divide a 62-bit gcd.
// Throughput: one request at a time; req_tready is high only while idle.
// Reset: synchronous, active high; returns the sequencer to idle, no response.
module rational_arithmetic_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[1:0]
   input  logic [1:0]   req_tuser,
   // a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95], zero fill
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0]
   output logic [1:0]   rsp_tuser,
   // res_num[31:0], res_den[62:32], zero fill
   output logic [63:0]  rsp_tdata
);

   localparam int W = rau_pkg::WIDE_W;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_A1, S_G1, S_G1W, S_A2, S_A2W, S_A3, S_A3W,
      S_A4, S_A5, S_R2, S_R2W, S_R3, S_R3W, S_OUT
   } state_type;

   state_type          state_ff;
   rau_pkg::mode_type  mode_ff;
   logic [31:0]        an_ff, bn_ff;
   logic [30:0]        ad_ff, bd_ff;
   // gcd pair, numerator sign and magnitude, denominator
   logic [W-1:0]       gx_ff, gy_ff, mag_ff, den_ff, lcm_ff, t_ff;
   logic signed [63:0] acc_ff;
   logic               neg_ff;
   logic [31:0]        rnum_ff;
   logic [30:0]        rden_ff;
   logic [1:0]         rst_ff;

   // shared divider
   logic [W-1:0] dn_ff, dd_ff, q_ff, r_ff;
   logic [6:0]   dc_ff;
   logic         dbusy_ff;
   logic         dstart;
   logic [W-1:0] dstart_n, dstart_d;
   logic [W:0]   rsh;

   assign rsh = {r_ff, dn_ff[W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (dstart) begin
         dbusy_ff <= 1'b1;
         dn_ff    <= dstart_n;
         dd_ff    <= dstart_d;
         q_ff     <= '0;
         r_ff     <= '0;
         dc_ff    <= 7'(W);
      end else if (dbusy_ff) begin
         // shift one quotient bit per cycle
         dn_ff <= dn_ff << 1;
         if (rsh >= {1'b0, dd_ff}) begin
            r_ff <= W'(rsh - {1'b0, dd_ff});
            q_ff <= {q_ff[W-2:0], 1'b1};
         end else begin
            r_ff <= rsh[W-1:0];
            q_ff <= {q_ff[W-2:0], 1'b0};
         end
         dc_ff <= dc_ff - 7'd1;
         if (dc_ff == 7'd1) dbusy_ff <= 1'b0;
      end
   end

   // shared 32x32 multiplier on magnitudes
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;
   logic [31:0]        abs_an, abs_bn;
   logic [63:0]        term;
   logic signed [63:0] sum;
   assign abs_an = an_ff[31] ? (~an_ff + 32'd1) : an_ff;
   assign abs_bn = bn_ff[31] ? (~bn_ff + 32'd1) : bn_ff;
   assign mul_p  = mul_a * mul_b;
   // apply the sign of a_num to the first add term, of b_num to the second
   assign term   = ((state_ff == S_A4) ? an_ff[31] : bn_ff[31]) ? (~mul_p + 64'd1) : mul_p;
   assign sum    = acc_ff + $signed(term);

   // select multiplier operands
   always_comb begin
      mul_a = abs_an;
      mul_b = 32'd1;
      case (state_ff)
         S_PREP: begin
            case (mode_ff)
               rau_pkg::MODE_MUL: mul_b = abs_bn;
               rau_pkg::MODE_DIV: mul_b = {1'b0, bd_ff};
               default: mul_b = 32'd1;
            endcase
         end
         S_A1: begin
            mul_a = {1'b0, ad_ff};
            case (mode_ff)
               rau_pkg::MODE_MUL: mul_b = {1'b0, bd_ff};
               rau_pkg::MODE_DIV: mul_b = abs_bn;
               default: mul_b = 32'd1;
            endcase
         end
         S_A3: begin mul_a = t_ff[31:0]; mul_b = {1'b0, bd_ff}; end
         S_A4: mul_b = gy_ff[31:0];
         S_A5: begin mul_a = abs_bn; mul_b = t_ff[31:0]; end
         default: ;
      endcase
   end

   // select divider operands
   always_comb begin
      dstart   = 1'b0;
      dstart_n = gx_ff;
      dstart_d = gy_ff;
      case (state_ff)
         S_G1: dstart = 1'b1;
         S_A2: begin dstart = 1'b1; dstart_n = W'(ad_ff); dstart_d = gx_ff; end
         S_A3: begin dstart = 1'b1; dstart_n = W'(bd_ff); dstart_d = gx_ff; end
         S_R2: begin dstart = 1'b1; dstart_n = mag_ff; dstart_d = gx_ff; end
         S_R3: begin dstart = 1'b1; dstart_n = den_ff; dstart_d = gx_ff; end
         default: ;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tuser  = rst_ff;
   assign rsp_tdata  = {1'b0, rden_ff, rnum_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (req_tvalid) begin
               mode_ff  <= rau_pkg::mode_type'(req_tuser);
               an_ff    <= req_tdata[31:0];
               ad_ff    <= req_tdata[62:32];
               bn_ff    <= req_tdata[94:63];
               bd_ff    <= req_tdata[125:95];
               state_ff <= S_PREP;
            end
            S_PREP: begin
               // check operands; load the gcd pair for add, else form the numerator magnitude
               rnum_ff <= '0;
               rden_ff <= 31'd1;
               if (ad_ff == '0 || (mode_ff != rau_pkg::MODE_RED && bd_ff == '0) ||
                   (mode_ff == rau_pkg::MODE_DIV && bn_ff == '0)) begin
                  rst_ff   <= rau_pkg::ST_DIVZ;
                  state_ff <= S_OUT;
               end else if (mode_ff == rau_pkg::MODE_ADD) begin
                  gx_ff    <= W'(ad_ff);
                  gy_ff    <= W'(bd_ff);
                  state_ff <= S_G1;
               end else begin
                  mag_ff   <= mul_p;
                  neg_ff   <= (mode_ff == rau_pkg::MODE_RED) ? an_ff[31] :
                              (an_ff[31] ^ bn_ff[31]);
                  state_ff <= S_A1;
               end
            end
            S_A1: begin
               // form the denominator and load the gcd pair
               den_ff   <= mul_p;
               gx_ff    <= mag_ff;
               gy_ff    <= mul_p;
               state_ff <= S_G1;
            end
            // Euclid: gcd of the pair, one divide per step
            S_G1: state_ff <= S_G1W;
            S_G1W: if (!dbusy_ff) begin
               gx_ff <= gy_ff;
               gy_ff <= r_ff;
               if (r_ff == '0)
                  state_ff <= (mode_ff == rau_pkg::MODE_ADD) ? S_A2 : S_R2;
               else
                  state_ff <= S_G1;
            end
            // add: ad/g, then lcm = (ad/g)*bd and bd/g
            S_A2: state_ff <= S_A2W;
            S_A2W: if (!dbusy_ff) begin
               t_ff     <= q_ff;
               state_ff <= S_A3;
            end
            S_A3: begin
               lcm_ff   <= mul_p;
               state_ff <= S_A3W;
            end
            S_A3W: if (!dbusy_ff) begin
               if (lcm_ff > W'(64'd2147483647)) begin
                  rst_ff   <= rau_pkg::ST_OVF;
                  state_ff <= S_OUT;
               end else begin
                  gy_ff    <= q_ff;
                  state_ff <= S_A4;
               end
            end
            S_A4: begin
               acc_ff   <= $signed(term);
               state_ff <= S_A5;
            end
            S_A5: begin
               if (sum > 64'sd2147483647 || sum < -64'sd2147483648) begin
                  rst_ff <= rau_pkg::ST_OVF;
               end else begin
                  rst_ff  <= rau_pkg::ST_OK;
                  rnum_ff <= sum[31:0];
                  rden_ff <= lcm_ff[30:0];
               end
               state_ff <= S_OUT;
            end
            // reduction: divide magnitude and denominator by the gcd
            S_R2: state_ff <= S_R2W;
            S_R2W: if (!dbusy_ff) begin
               mag_ff   <= q_ff;
               state_ff <= S_R3;
            end
            S_R3: state_ff <= S_R3W;
            S_R3W: if (!dbusy_ff) begin
               if (q_ff > W'(64'd2147483647) ||
                   mag_ff > (neg_ff ? W'(64'd2147483648) : W'(64'd2147483647))) begin
                  rst_ff <= rau_pkg::ST_OVF;
               end else begin
                  rst_ff  <= rau_pkg::ST_OK;
                  rnum_ff <= neg_ff ? (~mag_ff[31:0] + 32'd1) : mag_ff[31:0];
                  rden_ff <= q_ff[30:0];
               end
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### test/rational_arithmetic_unit_checker.sv
`timescale 1ns / 100ps

module rational_arithmetic_unit_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [1:0]   req_tuser,
   input  logic [127:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [1:0]   rsp_tuser,
   input  logic [63:0]  rsp_tdata,
   output int           fail_count,
   output int           pending_count,
   output int           rsp_count
);

   typedef struct packed {
      logic [rau_pkg::NUM_W-1:0] num;
      logic [rau_pkg::DEN_W-1:0] den;
      rau_pkg::status_type       status;
   } fraction_result_type;

   fraction_result_type result_queue[$];

   // Euclid on unsigned 64-bit values
   function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic logic [63:0] mag64(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic fraction_result_type bad_fraction(rau_pkg::status_type st);
      fraction_result_type r;
      r.num = '0;
      r.den = 31'd1;
      r.status = st;
      return r;
   endfunction

   // Reduce n/d by gcd; flag overflow if outside the output fields
   function automatic fraction_result_type reduce_fraction(longint n, logic [63:0] d);
      logic [63:0] g;
      fraction_result_type r;
      g = gcd64(mag64(n), d);
      if (g == 0) g = 64'd1;
      n = n / longint'(g);
      d = d / g;
      if (n > 64'sd2147483647 || n < -64'sd2147483648 || d > 64'd2147483647)
         return bad_fraction(rau_pkg::ST_OVF);
      r.num = n[31:0];
      r.den = d[30:0];
      r.status = rau_pkg::ST_OK;
      return r;
   endfunction

   function automatic fraction_result_type compute_fraction(rau_pkg::mode_type mode,
                                                            logic [127:0] data);
      longint an, bn, s, n;
      logic [63:0] ad, bd, l;
      fraction_result_type r;
      an = longint'($signed(data[31:0]));
      ad = 64'(data[62:32]);
      bn = longint'($signed(data[94:63]));
      bd = 64'(data[125:95]);
      if (mode == rau_pkg::MODE_RED) begin
         if (ad == 0) return bad_fraction(rau_pkg::ST_DIVZ);
         return reduce_fraction(an, ad);
      end
      if (ad == 0 || bd == 0) return bad_fraction(rau_pkg::ST_DIVZ);
      case (mode)
         rau_pkg::MODE_ADD: begin
            l = (ad / gcd64(ad, bd)) * bd;
            if (l > 64'd2147483647) return bad_fraction(rau_pkg::ST_OVF);
            s = an * longint'(l / ad) + bn * longint'(l / bd);
            if (s > 64'sd2147483647 || s < -64'sd2147483648)
               return bad_fraction(rau_pkg::ST_OVF);
            r.num = s[31:0];
            r.den = l[30:0];
            r.status = rau_pkg::ST_OK;
            return r;
         end
         rau_pkg::MODE_MUL: return reduce_fraction(an * bn, ad * bd);
         default: begin
            if (bn == 0) return bad_fraction(rau_pkg::ST_DIVZ);
            n = an * longint'(bd);
            if (bn < 0) n = -n;
            return reduce_fraction(n, ad * mag64(bn));
         end
      endcase
   endfunction

   // Predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      fraction_result_type want;
      int errs;
      errs = 0;
      if (reset) begin
         result_queue.delete();
         fail_count <= 0;
         rsp_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            result_queue.push_back(compute_fraction(rau_pkg::mode_type'(req_tuser),
                                                    req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            rsp_count <= rsp_count + 1;
            if (result_queue.size() == 0) begin
               $error("response with no request outstanding");
               errs++;
            end else begin
               want = result_queue.pop_front();
               if (rsp_tdata[31:0] !== want.num) begin
                  $error("res_num expected %0d actual %0d", $signed(want.num),
                         $signed(rsp_tdata[31:0]));
                  errs++;
               end
               if (rsp_tdata[62:32] !== want.den) begin
                  $error("res_den expected %0d actual %0d", want.den, rsp_tdata[62:32]);
                  errs++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_tuser);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending_count <= result_queue.size();
      end
   end

endmodule

### test/rational_arithmetic_unit_test.sv
`timescale 1ns / 100ps

module rational_arithmetic_unit_test;

   localparam int IDLE_LIMIT = 60000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [1:0]   req_tuser;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [1:0]   rsp_tuser;
   logic [63:0]  rsp_tdata;
   int           fail_count;
   int           pending_count;
   int           rsp_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           hold_off;
   int           idle_cycles;
   int           sent_count;

   rational_arithmetic_unit u_top (.*);

   rational_arithmetic_unit_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on cycles with no handshake
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Offer one request; valid stays up until the next call idles or offers
   task automatic send_request(rau_pkg::mode_type mode, logic [31:0] an, logic [30:0] ad,
                               logic [31:0] bn, logic [30:0] bd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= mode;
      req_tdata  <= {2'b0, bd, bn, ad, an};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_num();
      case ($urandom_range(5))
         0: return $urandom_range(20) - 10;
         1: return $urandom_range(2000) - 1000;
         2: return {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom)};
         3: return ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] pick_den();
      case ($urandom_range(5))
         0: return 31'($urandom_range(12)) + 31'd1;
         1: return 31'($urandom_range(5000)) + 31'd1;
         2: return 31'($urandom_range(65535)) + 31'd1;
         3: return 31'h7FFFFFFF;
         4: return $urandom_range(40) == 0 ? 31'd0 : 31'($urandom) | 31'd1;
         default: return 31'($urandom);
      endcase
   endfunction

   initial begin
      req_tvalid = 0;
      req_tuser = rau_pkg::MODE_ADD;
      req_tdata = '0;
      hold_off = 0;
      sent_count = 0;
      send_idle_pct = 15;
      recv_idle_pct = 68;
      reset = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: extremes, each mode, zero numerators and denominators
      send_request(rau_pkg::MODE_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
      send_request(rau_pkg::MODE_ADD, 32'd0, 31'd4, 32'd0, 31'd6);
      send_request(rau_pkg::MODE_ADD, 32'h7FFFFFFF, 31'd1, 32'd1, 31'd1);
      send_request(rau_pkg::MODE_ADD, 32'h80000000, 31'd1, 32'hFFFFFFFF, 31'd1);
      send_request(rau_pkg::MODE_ADD, 32'd1, 31'h7FFFFFFF, 32'd1, 31'h7FFFFFFE);
      send_request(rau_pkg::MODE_ADD, 32'd1, 31'd0, 32'd1, 31'd5);
      send_request(rau_pkg::MODE_MUL, 32'd6, 31'd4, 32'hFFFFFFFD, 31'd9);
      send_request(rau_pkg::MODE_MUL, 32'h80000000, 31'h7FFFFFFF, 32'h80000000,
                   31'h7FFFFFFF);
      send_request(rau_pkg::MODE_MUL, 32'h80000000, 31'd1, 32'hFFFFFFFF, 31'd1);
      send_request(rau_pkg::MODE_MUL, 32'd0, 31'd7, 32'd5, 31'd3);
      send_request(rau_pkg::MODE_MUL, 32'd3, 31'd7, 32'd5, 31'd0);
      send_request(rau_pkg::MODE_DIV, 32'd3, 31'd4, 32'd0, 31'd5);
      send_request(rau_pkg::MODE_DIV, 32'd3, 31'd4, 32'hFFFFFFFE, 31'd5);
      send_request(rau_pkg::MODE_DIV, 32'h80000000, 31'd1, 32'hFFFFFFFF, 31'd1);
      send_request(rau_pkg::MODE_DIV, 32'd0, 31'd9, 32'd7, 31'd2);
      send_request(rau_pkg::MODE_DIV, 32'd1, 31'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF);
      send_request(rau_pkg::MODE_RED, 32'd12, 31'd18, 32'hFFFFFFFF, 31'h7FFFFFFF);
      send_request(rau_pkg::MODE_RED, 32'h80000000, 31'h40000000, 32'd0, 31'd0);
      send_request(rau_pkg::MODE_RED, 32'd0, 31'd99, 32'd1, 31'd1);
      send_request(rau_pkg::MODE_RED, 32'd5, 31'd0, 32'd1, 31'd1);
      send_request(rau_pkg::MODE_RED, 32'h7FFFFFFF, 31'h7FFFFFFF, 32'd1, 31'd1);

      // Random: three idling phases, long receiver hold-off in the first
      for (int i = 0; i < 850; i++) begin
         if (i == 280) begin
            send_idle_pct = 68;
            recv_idle_pct = 15;
         end else if (i == 560) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (i == 100) hold_off = 3000;
         send_request(rau_pkg::mode_type'($urandom_range(3)), pick_num(), pick_den(),
                      pick_num(), pick_den());
      end
      req_tvalid <= 0;

      while (pending_count != 0) @(posedge clock);
      repeat (700) @(posedge clock);
      $display("Sent %0d requests over all four modes with edge operands, got %0d responses.",
               sent_count, rsp_count);
      $display("Idling covered sender-heavy, receiver-heavy, none, and a long receiver stall.");
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
